// File: rtl/utf8_encoder_with_byte_budget_defines.svh
// ----------------------------------------------------------------------------
// UTF-8 encoder assertion macros
// Shared concurrent assertion forms used by the encoder RTL.
// ----------------------------------------------------------------------------
`ifndef UTF8_ENCODER_WITH_BYTE_BUDGET_DEFINES_SVH
`define UTF8_ENCODER_WITH_BYTE_BUDGET_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define U8ENC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define U8ENC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/u8enc_pkg.sv
// ----------------------------------------------------------------------------
// u8enc_pkg
// Types, codes and constants shared by the UTF-8 encoder modules.
// ----------------------------------------------------------------------------
package u8enc_pkg;

    // Default width of the per-string byte budget.
    localparam int BUDGET_BITS_DEFAULT = 16;

    // Field widths.
    localparam int CP_W    = 32;
    localparam int LIMIT_W = 17;
    localparam int INDEX_W = 2;

    // Result status codes.
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_INVALID = 2'd1;
    localparam logic [1:0] STATUS_REFUSED = 2'd2;

    // Configuration register indexes.
    localparam logic [INDEX_W-1:0] REG_SINGLE_BYTE_MODE = 2'd0;
    localparam logic [INDEX_W-1:0] REG_BYTE_LIMIT       = 2'd1;

    // Code point boundaries.
    localparam logic [31:0] SURR_LO   = 32'h0000_D800;
    localparam logic [31:0] SURR_HI   = 32'h0000_DFFF;
    localparam logic [31:0] CP_MAX    = 32'h0010_FFFF;
    localparam logic [31:0] ONE_MAX   = 32'h0000_007F;
    localparam logic [31:0] TWO_MAX   = 32'h0000_07FF;
    localparam logic [31:0] THREE_MAX = 32'h0000_FFFF;
    localparam logic [31:0] RAW_MAX   = 32'h0000_00FF;

    // Lead and continuation byte marks.
    localparam logic [7:0] LEAD2     = 8'hC0;
    localparam logic [7:0] LEAD3     = 8'hE0;
    localparam logic [7:0] LEAD4     = 8'hF0;
    localparam logic [7:0] CONT_MARK = 8'h80;
    localparam logic [7:0] CONT_MASK = 8'h3F;

    // Limit encodings and the budget loaded when there is no limit.
    localparam logic [LIMIT_W-1:0] LIMIT_NONE = 17'h1FFFF;
    localparam logic [31:0]        UNLIMITED_BUDGET = 32'd100000;

    // One encoded character on its way to the byte serializer.
    typedef struct packed {
        logic [3:0][7:0] bytes;     // bytes[0] goes out first
        logic [1:0]      last_idx;  // index of the final byte
        logic [1:0]      status;
    } group_t;

endpackage

// File: rtl/u8enc_if.sv
// ----------------------------------------------------------------------------
// u8enc interfaces
// Valid/ready channels for code points, encoded bytes and register writes.
// ----------------------------------------------------------------------------

// Code point requests.
interface u8enc_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] code_point;
    logic               start_of_string;

    modport source (output valid, output code_point, output start_of_string, input ready);
    modport sink   (input valid, input code_point, input start_of_string, output ready);
endinterface

// Encoded byte results.
interface u8enc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic [1:0] status;

    modport source (output valid, output out_byte, output last_of_run, output status,
                    input ready);
    modport sink   (input valid, input out_byte, input last_of_run, input status,
                    output ready);
endinterface

// Register write requests.
interface u8enc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [16:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/u8enc_encode.sv
// ----------------------------------------------------------------------------
// u8enc_encode
// Input register, configuration registers, byte budget and UTF-8 encoding.
// ----------------------------------------------------------------------------
module u8enc_encode
    import u8enc_pkg::*;
#(
    parameter int BUDGET_BITS = BUDGET_BITS_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    u8enc_cfg_if.sink         cfg,
    u8enc_in_if.sink          chars,
    output logic              grp_valid,
    input  logic              grp_ready,
    output group_t            grp
);

    // Largest value the budget register can hold.
    localparam logic [31:0] BudgetMax = 32'((33'd1 << BUDGET_BITS) - 33'd1);

    logic                   mode_reg;
    logic [LIMIT_W-1:0]     limit_reg;
    logic [BUDGET_BITS-1:0] budget_reg;
    logic [BUDGET_BITS-1:0] budget_next;
    logic                   trunc_reg;
    logic                   trunc_next;
    logic                   valid_reg;
    logic [31:0]            cp_reg;
    logic                   sos_reg;

    logic [31:0]            lim_raw;
    logic [BUDGET_BITS-1:0] load_value;
    logic [BUDGET_BITS-1:0] budget_eff;
    logic                   trunc_eff;
    logic [2:0]             len;
    logic                   fits;
    logic                   xfer;

    // Register writes are always taken.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b0;
            limit_reg <= LIMIT_NONE;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_SINGLE_BYTE_MODE: mode_reg  <= cfg.data[0];
                REG_BYTE_LIMIT:       limit_reg <= cfg.data;
                default:              ;
            endcase
        end
    end

    // Input register: refilled whenever the held character moves on.
    assign chars.ready = !valid_reg || grp_ready;
    assign xfer        = valid_reg && grp_ready;
    assign grp_valid   = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (chars.ready)
        begin
            valid_reg <= chars.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready)
        begin
            cp_reg  <= $unsigned(chars.code_point);
            sos_reg <= chars.start_of_string;
        end
    end

    // Budget loaded at the start of a string, saturated to the register width.
    always_comb
    begin
        if (limit_reg == LIMIT_NONE)
        begin
            lim_raw = UNLIMITED_BUDGET;
        end
        else if (limit_reg[LIMIT_W-1])
        begin
            lim_raw = 32'd0;
        end
        else
        begin
            lim_raw = {16'd0, limit_reg[15:0]};
        end
        load_value = (lim_raw > BudgetMax) ? BudgetMax[BUDGET_BITS-1:0]
                                           : lim_raw[BUDGET_BITS-1:0];
    end

    assign budget_eff = sos_reg ? load_value : budget_reg;
    assign trunc_eff  = sos_reg ? 1'b0 : trunc_reg;

    // Encoded length; zero marks an invalid code point.
    always_comb
    begin
        if (cp_reg[31] || (cp_reg >= SURR_LO && cp_reg <= SURR_HI) || cp_reg > CP_MAX)
        begin
            len = 3'd0;
        end
        else if (mode_reg)
        begin
            len = (cp_reg > RAW_MAX) ? 3'd0 : 3'd1;
        end
        else if (cp_reg <= ONE_MAX)
        begin
            len = 3'd1;
        end
        else if (cp_reg <= TWO_MAX)
        begin
            len = 3'd2;
        end
        else if (cp_reg <= THREE_MAX)
        begin
            len = 3'd3;
        end
        else
        begin
            len = 3'd4;
        end
    end

    assign fits = {{(BUDGET_BITS-3){1'b0}}, len} <= budget_eff;

    // Result group and next budget state.
    always_comb
    begin
        grp.bytes    = '0;
        grp.last_idx = 2'd0;
        grp.status   = STATUS_OK;
        budget_next  = budget_eff;
        trunc_next   = trunc_eff;
        if (trunc_eff)
        begin
            grp.status = STATUS_REFUSED;
        end
        else if (len == 3'd0)
        begin
            grp.status = STATUS_INVALID;
        end
        else if (!fits)
        begin
            grp.status = STATUS_REFUSED;
            trunc_next = 1'b1;
        end
        else
        begin
            budget_next  = budget_eff - {{(BUDGET_BITS-3){1'b0}}, len};
            grp.last_idx = 2'(len - 3'd1);
            case (len)
                3'd1:
                begin
                    grp.bytes[0] = cp_reg[7:0];
                end
                3'd2:
                begin
                    grp.bytes[0] = LEAD2 | cp_reg[13:6];
                    grp.bytes[1] = CONT_MARK | (cp_reg[7:0] & CONT_MASK);
                end
                3'd3:
                begin
                    grp.bytes[0] = LEAD3 | cp_reg[19:12];
                    grp.bytes[1] = CONT_MARK | (cp_reg[13:6] & CONT_MASK);
                    grp.bytes[2] = CONT_MARK | (cp_reg[7:0] & CONT_MASK);
                end
                default:
                begin
                    grp.bytes[0] = LEAD4 | cp_reg[25:18];
                    grp.bytes[1] = CONT_MARK | (cp_reg[19:12] & CONT_MASK);
                    grp.bytes[2] = CONT_MARK | (cp_reg[13:6] & CONT_MASK);
                    grp.bytes[3] = CONT_MARK | (cp_reg[7:0] & CONT_MASK);
                end
            endcase
        end
    end

    // String state advances as each character is handed on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_reg <= '0;
            trunc_reg  <= 1'b0;
        end
        else if (xfer)
        begin
            budget_reg <= budget_next;
            trunc_reg  <= trunc_next;
        end
    end

endmodule

// File: rtl/u8enc_serial.sv
// ----------------------------------------------------------------------------
// u8enc_serial
// Holds one encoded character; presents one byte per cycle unless utf8 stalls.
// ----------------------------------------------------------------------------
`include "utf8_encoder_with_byte_budget_defines.svh"

module u8enc_serial
    import u8enc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       grp_valid,
    output logic       grp_ready,
    input  group_t     grp,
    u8enc_out_if.source utf8
);

    logic       valid_reg;
    group_t     grp_reg;
    logic [1:0] idx_reg;
    logic       is_last;
    logic       take;
    logic       load;

    assign is_last = idx_reg == grp_reg.last_idx;
    assign take    = valid_reg && utf8.ready;

    // A new character loads once the held one has sent its final byte.
    assign grp_ready = !valid_reg || (utf8.ready && is_last);
    assign load      = grp_valid && grp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= 2'd0;
        end
        else if (take)
        begin
            if (is_last)
            begin
                valid_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            grp_reg <= grp;
        end
    end

    // Output byte selected by the running index.
    assign utf8.valid       = valid_reg;
    assign utf8.out_byte    = grp_reg.bytes[idx_reg];
    assign utf8.last_of_run = is_last;
    assign utf8.status      = grp_reg.status;

    `U8ENC_ASSERT_SAME(a_idx_in_range, clk, rst_n, valid_reg, idx_reg <= grp_reg.last_idx,
        "byte index ran past the end of the character")
    `U8ENC_ASSERT_SAME(a_flag_single, clk, rst_n, valid_reg && grp_reg.status != STATUS_OK,
        is_last && utf8.out_byte == 8'd0, "flagged result must be a lone zero byte")
    `U8ENC_ASSERT_NEXT(a_drain, clk, rst_n, take && is_last && !grp_valid, !valid_reg,
        "result still valid after the final byte was taken")
    `U8ENC_ASSERT_NEXT(a_hold, clk, rst_n, valid_reg && !utf8.ready,
        valid_reg && $stable(idx_reg), "stalled byte moved")

endmodule

// File: rtl/utf8_encoder_with_byte_budget.sv
// ----------------------------------------------------------------------------
// utf8_encoder_with_byte_budget
// UTF-8 encoder with invalid-code flagging and a per-string byte budget.
// ----------------------------------------------------------------------------
// Usage:
//   chars carries one code point per request, with start_of_string set on the
//   first character of each string; that reloads the budget from byte_limit.
//   utf8 returns one result per output byte; last_of_run marks the final one
//   of each character. Invalid or refused characters give one zero byte with
//   status 1 or 2. cfg writes single_byte_mode (index 0) and byte_limit
//   (index 1); it is always ready and must only be used while idle.
// Timing:
//   The first byte of a character passes through the input register and
//   then the output register of the serializer before it is valid on utf8.
//   The output register sends one byte per cycle while utf8 is ready; a
//   character gives 1 to 4 bytes, its encoded length. A new request is
//   accepted while earlier bytes are still being sent.
// Reset:
//   Clears both pipeline stages, sets multibyte mode and no limit, and leaves
//   the budget at zero until the first start of string.
// Stalls:
//   A low ready on utf8 holds the current byte; the input register then fills
//   and chars.ready drops until the output moves again.
// ----------------------------------------------------------------------------
module utf8_encoder_with_byte_budget
    import u8enc_pkg::*;
#(
    parameter int BUDGET_BITS = BUDGET_BITS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    u8enc_cfg_if.sink   cfg,
    u8enc_in_if.sink    chars,
    u8enc_out_if.source utf8
);

    logic   grp_valid;
    logic   grp_ready;
    group_t grp;

    // Encoding stage.
    u8enc_encode #(
        .BUDGET_BITS (BUDGET_BITS)
    ) u_encode (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .chars     (chars),
        .grp_valid (grp_valid),
        .grp_ready (grp_ready),
        .grp       (grp)
    );

    // Byte serializer and output register.
    u8enc_serial u_serial (
        .clk       (clk),
        .rst_n     (rst_n),
        .grp_valid (grp_valid),
        .grp_ready (grp_ready),
        .grp       (grp),
        .utf8      (utf8)
    );

endmodule
